### sv/xmbc_pkg.sv
`default_nettype none
package xmbc_pkg;

   localparam int BLOCK_W = 64;
   localparam int WORD_W = 32;
   localparam int KEY_LEN_W = 6;
   localparam int CSR_INDEX_W = 3;

   localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

   // Direction codes.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Status codes.
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_SHORT_KEY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_0_7 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_8_15 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;

   typedef logic [3:0][WORD_W-1:0] key_words_type;

   typedef struct packed {
      logic               decrypt;
      logic               err;
      logic               fin;
      logic [BLOCK_W-1:0] blk;
   } pipe_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] result_block;
      logic               status;
      logic               final_out;
   } result_type;

   // Running XTEA sum after n additions of the delta, modulo 2^32.
   function automatic logic [WORD_W-1:0] sum_at(input int unsigned n);
      logic [63:0] prod;
      prod = 64'(n) * 64'(XTEA_DELTA);
      return prod[WORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

### sv/xmbc_if.sv
`default_nettype none
interface xmbc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [xmbc_pkg::BLOCK_W-1:0]  data_block;
   logic                          final_block;

   modport source (output valid, output opcode, output data_block, output final_block,
                   input ready);
   modport sink (input valid, input opcode, input data_block, input final_block,
                 output ready);
endinterface

interface xmbc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [xmbc_pkg::BLOCK_W-1:0]  result_block;
   logic                          status;
   logic                          final_out;

   modport source (output valid, output result_block, output status, output final_out,
                   input ready);
   modport sink (input valid, input result_block, input status, input final_out,
                 output ready);
endinterface

interface xmbc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [xmbc_pkg::CSR_INDEX_W-1:0]  index;
   logic [xmbc_pkg::BLOCK_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/xmbc_round_cell.sv
`default_nettype none
module xmbc_round_cell #(
   parameter int ROUNDS = 32,
   parameter int IDX = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire xmbc_pkg::pipe_type      in_data,
   input  wire xmbc_pkg::key_words_type key_words,
   output logic                         out_valid,
   output xmbc_pkg::pipe_type           out_data
);
   import xmbc_pkg::*;

   // Each cell is one half of an XTEA round; even cells do the first half.
   localparam int RND = IDX / 2;
   localparam bit ODD = (IDX % 2) == 1;
   localparam logic [WORD_W-1:0] ENC_SUM = ODD ? sum_at(RND + 1) : sum_at(RND);
   localparam logic [WORD_W-1:0] DEC_SUM = ODD ? sum_at(ROUNDS - RND - 1)
                                               : sum_at(ROUNDS - RND);
   localparam logic [1:0] ENC_KEY = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
   localparam logic [1:0] DEC_KEY = ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

   logic              valid_ff, valid_in;
   pipe_type          data_ff, data_in;
   logic              is_dec, to_b;
   logic [WORD_W-1:0] word_a, word_b, src, dst, f_val, tweak, upd;
   logic [1:0]        kidx;
   logic [WORD_W-1:0] sum;

   always_comb begin
      is_dec = in_data.decrypt == OP_DECRYPT;
      // Encryption updates the low word first, decryption the high word first.
      to_b = ODD ^ is_dec;
      word_a = in_data.blk[WORD_W-1:0];
      word_b = in_data.blk[BLOCK_W-1:WORD_W];
      src = to_b ? word_a : word_b;
      dst = to_b ? word_b : word_a;
      sum = is_dec ? DEC_SUM : ENC_SUM;
      kidx = is_dec ? DEC_KEY : ENC_KEY;
      f_val = ((src << 4) ^ (src >> 5)) + src;
      tweak = f_val ^ (sum + key_words[kidx]);
      upd = is_dec ? (dst - tweak) : (dst + tweak);
      data_in = in_data;
      data_in.blk = to_b ? {upd, word_a} : {word_b, upd};
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule
`default_nettype wire

### sv/xmbc_mix.sv
`default_nettype none
module xmbc_mix #(
   parameter bit INVERSE = 1'b0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire xmbc_pkg::pipe_type      in_data,
   input  wire logic [xmbc_pkg::BLOCK_W-1:0] m0,
   input  wire logic [xmbc_pkg::BLOCK_W-1:0] m1,
   output logic                         out_valid,
   output xmbc_pkg::pipe_type           out_data
);
   import xmbc_pkg::*;

   // The forward mix acts on encrypt beats, the inverse mix on decrypt beats;
   // other beats pass through unchanged.
   localparam logic ACTIVE_OP = INVERSE ? OP_DECRYPT : OP_ENCRYPT;

   logic               v1_ff, v1_in, v2_ff, v2_in;
   pipe_type           d1_ff, d1_in, d2_ff, d2_in;
   logic [BLOCK_W-1:0] mx, t, u, v;

   always_comb begin
      mx = m0 ^ m1;
      if (INVERSE) begin
         t = in_data.blk - mx;
         u = {t[16:0], t[BLOCK_W-1:17]} ^ m1;
         v = {u[30:0], u[BLOCK_W-1:31]};
      end else begin
         t = in_data.blk + m0;
         u = {t[32:0], t[BLOCK_W-1:33]} ^ m1;
         v = {u[46:0], u[BLOCK_W-1:47]};
      end
      d1_in = in_data;
      if (in_data.decrypt == ACTIVE_OP) begin
         d1_in.blk = v;
      end
      v1_in = in_valid;

      d2_in = d1_ff;
      if (d1_ff.decrypt == ACTIVE_OP) begin
         d2_in.blk = INVERSE ? (d1_ff.blk - m0) : (d1_ff.blk + mx);
      end
      v2_in = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data = d2_ff;
endmodule
`default_nettype wire

### sv/xmbc_out_skid.sv
`default_nettype none
module xmbc_out_skid (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire xmbc_pkg::pipe_type in_data,
   input  wire logic            out_ready,
   output logic                 en,
   output logic                 out_valid,
   output xmbc_pkg::result_type out_data
);
   import xmbc_pkg::*;

   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in, skid_data_ff, skid_data_in, incoming;

   always_comb begin
      incoming.result_block = in_data.err ? '0 : in_data.blk;
      incoming.status = in_data.err ? STATUS_SHORT_KEY : STATUS_OK;
      incoming.final_out = in_data.fin;

      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;

      // While the skid stage holds a beat the pipeline is frozen.
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_ready) begin
            out_valid_in = 1'b1;
            out_data_in = incoming;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in = incoming;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign en = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !out_ready))
      else $error("skid stage filled without a stalled output");

   a_short_key_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.status == STATUS_SHORT_KEY)
      |-> out_data_ff.result_block == '0)
      else $error("short-key result carries a non-zero block");
`endif
endmodule
`default_nettype wire

### sv/xtea_mix_block_cipher.sv
// XTEA block cipher with a keyed 64-bit mix, fully unrolled. One 64-bit block
// is taken per clock unless the result side stalls; a result passes through
// two inverse-mix stages, one cell per half round, two mix stages and the
// output register, and absent stalls the sustained rate is one block per
// cycle. When the result side stalls, a skid stage catches the beat in flight
// and then the whole pipeline holds. Key registers are written through the csr
// channel, which is always ready; write them only while no block is in flight.
// A key length below 16 gives status 1 and a zero block.
`default_nettype none
module xtea_mix_block_cipher #(
   parameter int ROUNDS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   xmbc_req_if.sink    req_ch,
   xmbc_rsp_if.source  rsp_ch,
   xmbc_csr_if.sink    csr_ch
);
   import xmbc_pkg::*;

   localparam int CELLS = 2 * ROUNDS;

   logic [BLOCK_W-1:0]   key0_ff, key1_ff, key2_ff, key3_ff;
   logic [KEY_LEN_W-1:0] key_len_ff;
   key_words_type        key_words;
   logic [BLOCK_W-1:0]   m0, m1;
   logic                 en, short_key;
   pipe_type             entry, tail_data;
   logic                 tail_valid;
   logic [CELLS:0]       cv;
   pipe_type             cd [CELLS+1];
   result_type           result;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
         key_len_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_KEY_0_7: key0_ff <= csr_ch.data;
            REG_KEY_8_15: key1_ff <= csr_ch.data;
            REG_KEY_16_23: key2_ff <= csr_ch.data;
            REG_KEY_24_31: key3_ff <= csr_ch.data;
            REG_KEY_LENGTH: key_len_ff <= csr_ch.data[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      key_words = {key1_ff, key0_ff};
      short_key = key_len_ff[KEY_LEN_W-1:4] == '0;
      // Lengths of 32 and above take the mix keys from the upper half.
      m0 = key_len_ff[KEY_LEN_W-1] ? key2_ff : key0_ff;
      m1 = key_len_ff[KEY_LEN_W-1] ? key3_ff : key1_ff;
      entry.decrypt = req_ch.opcode;
      entry.err = short_key;
      entry.fin = req_ch.final_block;
      entry.blk = req_ch.data_block;
   end

   assign req_ch.ready = en;

   xmbc_mix #(.INVERSE(1'b1)) u_unmix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid && en),
      .in_data   (entry),
      .m0        (m0),
      .m1        (m1),
      .out_valid (cv[0]),
      .out_data  (cd[0])
   );

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      xmbc_round_cell #(.ROUNDS(ROUNDS), .IDX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cv[g]),
         .in_data   (cd[g]),
         .key_words (key_words),
         .out_valid (cv[g+1]),
         .out_data  (cd[g+1])
      );
   end

   xmbc_mix #(.INVERSE(1'b0)) u_mix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cv[CELLS]),
      .in_data   (cd[CELLS]),
      .m0        (m0),
      .m1        (m1),
      .out_valid (tail_valid),
      .out_data  (tail_data)
   );

   xmbc_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tail_valid),
      .in_data   (tail_data),
      .out_ready (rsp_ch.ready),
      .en        (en),
      .out_valid (rsp_ch.valid),
      .out_data  (result)
   );

   assign rsp_ch.result_block = result.result_block;
   assign rsp_ch.status = result.status;
   assign rsp_ch.final_out = result.final_out;
endmodule
`default_nettype wire
